@@ rtl/pid_position_incremental_unit_defines.svh @@
// assertion macros shared by the pid unit rtl
`ifndef PID_POSITION_INCREMENTAL_UNIT_DEFINES_SVH
`define PID_POSITION_INCREMENTAL_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PIDPI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PIDPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pidpi_pkg.sv @@
// shared types and constants of the pid unit
package pidpi_pkg;

	// number formats
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int SUM_WIDTH  = 48;

	// derived widths
	localparam int ERR_W   = DATA_WIDTH + 1;
	localparam int OPP_W   = DATA_WIDTH + 2;
	localparam int OPD_W   = DATA_WIDTH + 3;
	localparam int SPLIT   = SUM_WIDTH / 2;
	localparam int ACC_W   = DATA_WIDTH + SUM_WIDTH + 2;
	localparam int SH_W    = ACC_W - FRAC_BITS;
	localparam int ILIM_W  = SUM_WIDTH - 1;
	localparam int OLIM_W  = DATA_WIDTH - 1;

	// product widths
	localparam int PROD_P_W  = DATA_WIDTH + OPP_W;
	localparam int PROD_IL_W = DATA_WIDTH + SPLIT + 1;
	localparam int PROD_IH_W = DATA_WIDTH + SUM_WIDTH - SPLIT;
	localparam int PROD_D_W  = DATA_WIDTH + OPD_W;

	// saturation bounds
	localparam logic [DATA_WIDTH-1:0] DRIVE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] DRIVE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [SUM_WIDTH-1:0]  SUM_MAX   = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic [SUM_WIDTH-1:0]  SUM_MIN   = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	// apb port geometry: 64-bit registers at 8-byte spacing
	localparam int APB_DW    = 64;
	localparam int APB_AW    = 6;
	localparam int REG_SHIFT = 3;

	// register map
	typedef enum logic [APB_AW-REG_SHIFT-1:0] {
		REG_MODE        = 3'd0,
		REG_GAIN_P      = 3'd1,
		REG_GAIN_I      = 3'd2,
		REG_GAIN_D      = 3'd3,
		REG_INT_CLAMP   = 3'd4,
		REG_INT_LIMIT   = 3'd5,
		REG_OUT_CLAMP   = 3'd6,
		REG_OUT_LIMIT   = 3'd7
	} reg_idx_t;

	// mode codes
	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	// input transaction payload
	typedef struct packed {
		logic [DATA_WIDTH-1:0] target;
		logic [DATA_WIDTH-1:0] measured;
		logic                  clear_history;
	} sample_t;

	// output transaction payload
	typedef struct packed {
		logic [DATA_WIDTH-1:0] drive;
		logic                  clamped;
	} result_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic                  mode;
		logic [DATA_WIDTH-1:0] gain_p;
		logic [DATA_WIDTH-1:0] gain_i;
		logic [DATA_WIDTH-1:0] gain_d;
		logic                  int_clamp_on;
		logic [ILIM_W-1:0]     int_limit;
		logic                  out_clamp_on;
		logic [OLIM_W-1:0]     out_limit;
	} cfg_t;

endpackage

@@ rtl/pidpi_regs.sv @@
// apb configuration register file of the pid unit
module pidpi_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidpi_pkg::APB_AW-1:0]  paddr,
	input  logic [pidpi_pkg::APB_DW-1:0]  pwdata,
	output logic [pidpi_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	output pidpi_pkg::cfg_t               cfg
);
	import pidpi_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:REG_SHIFT]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_POSITIONAL;
			cfg_q.gain_p       <= '0;
			cfg_q.gain_i       <= '0;
			cfg_q.gain_d       <= '0;
			cfg_q.int_clamp_on <= 1'b0;
			cfg_q.int_limit    <= '1;
			cfg_q.out_clamp_on <= 1'b0;
			cfg_q.out_limit    <= '1;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE:      cfg_q.mode         <= pwdata[0];
				REG_GAIN_P:    cfg_q.gain_p       <= pwdata[DATA_WIDTH-1:0];
				REG_GAIN_I:    cfg_q.gain_i       <= pwdata[DATA_WIDTH-1:0];
				REG_GAIN_D:    cfg_q.gain_d       <= pwdata[DATA_WIDTH-1:0];
				REG_INT_CLAMP: cfg_q.int_clamp_on <= pwdata[0];
				REG_INT_LIMIT: cfg_q.int_limit    <= pwdata[ILIM_W-1:0];
				REG_OUT_CLAMP: cfg_q.out_clamp_on <= pwdata[0];
				REG_OUT_LIMIT: cfg_q.out_limit    <= pwdata[OLIM_W-1:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_MODE:      prdata = APB_DW'(cfg_q.mode);
			REG_GAIN_P:    prdata = APB_DW'(cfg_q.gain_p);
			REG_GAIN_I:    prdata = APB_DW'(cfg_q.gain_i);
			REG_GAIN_D:    prdata = APB_DW'(cfg_q.gain_d);
			REG_INT_CLAMP: prdata = APB_DW'(cfg_q.int_clamp_on);
			REG_INT_LIMIT: prdata = APB_DW'(cfg_q.int_limit);
			REG_OUT_CLAMP: prdata = APB_DW'(cfg_q.out_clamp_on);
			REG_OUT_LIMIT: prdata = APB_DW'(cfg_q.out_limit);
		endcase
	end

endmodule

@@ rtl/pid_position_incremental_unit.sv @@
// pid controller, positional or incremental, signed q16.16 fixed point
//
// channels: sample (target, measured, clear_history) in, result (drive,
// clamped) out, both valid/ready; a transaction moves when valid and
// ready are high at a rising clk edge. gains, limits and mode are set
// through the apb port (64-bit registers, 8-byte spacing) while idle.
// throughput: one sample per cycle while the receiver takes results.
// stages are input register, operand register, product register, sum
// register and result register; the error sum and error history close
// their loop in the operand stage and the previous drive closes its
// loop in the result stage, so nothing holds the next sample back.
// reset (arst_n low) clears the error sum, error history, previous drive
// and all valid flags, and loads the register defaults.
// when the receiver stalls, the result register holds and the stages
// behind it keep filling; sample_ready drops only once all five stages
// are full.
`include "pid_position_incremental_unit_defines.svh"

module pid_position_incremental_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidpi_pkg::APB_AW-1:0]  paddr,
	input  logic [pidpi_pkg::APB_DW-1:0]  pwdata,
	output logic [pidpi_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  pidpi_pkg::sample_t            sample_data,
	output logic                          result_valid,
	input  logic                          result_ready,
	output pidpi_pkg::result_t            result_data
);
	import pidpi_pkg::*;

	cfg_t cfg;

	// configuration registers
	pidpi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline registers
	logic                        valid_s1, valid_s2, valid_s3, valid_s4;
	sample_t                     sample_s1;
	logic                        mode_s2, mode_s3, mode_s4;
	logic                        clear_s2, clear_s3, clear_s4;
	logic signed [OPP_W-1:0]     op_p_s2;
	logic signed [SUM_WIDTH-1:0] op_i_s2;
	logic signed [OPD_W-1:0]     op_d_s2;
	logic signed [PROD_P_W-1:0]  prod_p_s3;
	logic signed [PROD_IL_W-1:0] prod_il_s3;
	logic signed [PROD_IH_W-1:0] prod_ih_s3;
	logic signed [PROD_D_W-1:0]  prod_d_s3;
	logic signed [ACC_W-1:0]     acc_s4;
	logic                        result_valid_q;
	result_t                     result_q;

	// controller state
	logic signed [SUM_WIDTH-1:0]  error_sum_q;
	logic signed [ERR_W-1:0]      prev_err_q;
	logic signed [ERR_W-1:0]      prev2_err_q;
	logic signed [DATA_WIDTH-1:0] prev_drive_q;

	// per-stage flow control
	logic ready1, ready2, ready3, ready4;
	logic mv1, mv2, mv3, mv4;

	assign ready4       = !result_valid_q || result_ready;
	assign ready3       = !valid_s4 || ready4;
	assign ready2       = !valid_s3 || ready3;
	assign ready1       = !valid_s2 || ready2;
	assign sample_ready = !valid_s1 || ready1;
	assign mv1          = valid_s1 && ready1;
	assign mv2          = valid_s2 && ready2;
	assign mv3          = valid_s3 && ready3;
	assign mv4          = valid_s4 && ready4;

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (ready1) begin
				valid_s2 <= valid_s1;
			end
			if (ready2) begin
				valid_s3 <= valid_s2;
			end
			if (ready3) begin
				valid_s4 <= valid_s3;
			end
			if (ready4) begin
				result_valid_q <= valid_s4;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample_data;
		end
	end

	// error and history selection
	logic signed [ERR_W-1:0]     err;
	logic                        clr;
	logic signed [ERR_W-1:0]     pe_eff;
	logic signed [ERR_W-1:0]     ppe_eff;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [SUM_WIDTH-1:0] sum_sat;
	logic signed [SUM_WIDTH-1:0] sum_lim;
	logic signed [SUM_WIDTH-1:0] sum_neg_lim;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic signed [OPP_W-1:0]     d1;
	logic signed [OPD_W-1:0]     d2;

	assign err = $signed({sample_s1.target[DATA_WIDTH-1], sample_s1.target})
		- $signed({sample_s1.measured[DATA_WIDTH-1], sample_s1.measured});
	assign clr     = sample_s1.clear_history && (cfg.mode == MODE_INCREMENTAL);
	assign pe_eff  = clr ? '0 : prev_err_q;
	assign ppe_eff = clr ? '0 : prev2_err_q;

	// first and second error differences
	assign d1 = OPP_W'(err) - OPP_W'(pe_eff);
	assign d2 = OPD_W'(err) - (OPD_W'(pe_eff) <<< 1) + OPD_W'(ppe_eff);

	// error sum with saturation and optional clamp
	assign sum_wide    = (SUM_WIDTH+1)'(error_sum_q) + (SUM_WIDTH+1)'(err);
	assign sum_lim     = $signed({1'b0, cfg.int_limit});
	assign sum_neg_lim = -sum_lim;

	always_comb begin
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_sat = sum_wide[SUM_WIDTH] ? $signed(SUM_MIN) : $signed(SUM_MAX);
		end else begin
			sum_sat = sum_wide[SUM_WIDTH-1:0];
		end
		sum_next = sum_sat;
		if (cfg.int_clamp_on) begin
			priority if (sum_sat > sum_lim) begin
				sum_next = sum_lim;
			end else if (sum_sat < sum_neg_lim) begin
				sum_next = sum_neg_lim;
			end else begin
				sum_next = sum_sat;
			end
		end
	end

	// operand register and state update
	always_ff @(posedge clk) begin
		if (mv1) begin
			mode_s2  <= cfg.mode;
			clear_s2 <= clr;
			if (cfg.mode == MODE_INCREMENTAL) begin
				op_p_s2 <= d1;
				op_i_s2 <= SUM_WIDTH'(err);
				op_d_s2 <= d2;
			end else begin
				op_p_s2 <= OPP_W'(err);
				op_i_s2 <= sum_next;
				op_d_s2 <= OPD_W'(d1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
			prev2_err_q <= '0;
		end else if (mv1) begin
			if (cfg.mode == MODE_INCREMENTAL) begin
				prev2_err_q <= pe_eff;
			end else begin
				error_sum_q <= sum_next;
			end
			prev_err_q <= err;
		end
	end

	// gain products, integral operand split in two halves
	logic signed [PROD_P_W-1:0]  prod_p;
	logic signed [PROD_IL_W-1:0] prod_il;
	logic signed [PROD_IH_W-1:0] prod_ih;
	logic signed [PROD_D_W-1:0]  prod_d;

	assign prod_p  = $signed(cfg.gain_p) * op_p_s2;
	assign prod_il = $signed(cfg.gain_i) * $signed({1'b0, op_i_s2[SPLIT-1:0]});
	assign prod_ih = $signed(cfg.gain_i) * $signed(op_i_s2[SUM_WIDTH-1:SPLIT]);
	assign prod_d  = $signed(cfg.gain_d) * op_d_s2;

	always_ff @(posedge clk) begin
		if (mv2) begin
			mode_s3    <= mode_s2;
			clear_s3   <= clear_s2;
			prod_p_s3  <= prod_p;
			prod_il_s3 <= prod_il;
			prod_ih_s3 <= prod_ih;
			prod_d_s3  <= prod_d;
		end
	end

	// sum of the terms
	logic signed [ACC_W-1:0] acc;

	assign acc = ACC_W'(prod_p_s3) + ACC_W'(prod_d_s3)
		+ (ACC_W'(prod_ih_s3) <<< SPLIT) + ACC_W'(prod_il_s3);

	always_ff @(posedge clk) begin
		if (mv3) begin
			mode_s4  <= mode_s3;
			clear_s4 <= clear_s3;
			acc_s4   <= acc;
		end
	end

	// previous drive, scaling, output clamp and saturation
	logic signed [DATA_WIDTH-1:0] prev_term;
	logic signed [ACC_W-1:0]      full;
	logic signed [SH_W-1:0]       scaled;
	logic signed [DATA_WIDTH-1:0] hi_b;
	logic signed [DATA_WIDTH-1:0] lo_b;
	logic signed [DATA_WIDTH-1:0] drive;
	logic                         hit;

	assign prev_term = (mode_s4 == MODE_INCREMENTAL && !clear_s4) ? prev_drive_q : '0;
	assign full      = acc_s4 + (ACC_W'(prev_term) <<< FRAC_BITS);
	assign scaled    = full[ACC_W-1:FRAC_BITS];
	assign hi_b      = cfg.out_clamp_on ? $signed({1'b0, cfg.out_limit}) : $signed(DRIVE_MAX);
	assign lo_b      = cfg.out_clamp_on ? -$signed({1'b0, cfg.out_limit})
		: $signed(DRIVE_MIN);

	always_comb begin
		priority if (scaled < SH_W'(lo_b)) begin
			drive = lo_b;
			hit   = 1'b1;
		end else if (scaled > SH_W'(hi_b)) begin
			drive = hi_b;
			hit   = 1'b1;
		end else begin
			drive = scaled[DATA_WIDTH-1:0];
			hit   = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (mv4) begin
			result_q.drive   <= drive;
			result_q.clamped <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_drive_q <= '0;
		end else if (mv4 && mode_s4 == MODE_INCREMENTAL) begin
			prev_drive_q <= drive;
		end
	end

	// checks
	`PIDPI_ASSERT_IMPL(a_stall_only_when_full, !sample_ready,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && result_valid_q,
		"sample channel stalled with a bubble in the pipeline")
	`PIDPI_ASSERT_NEXT(a_prev_drive_follows, mv4 && mode_s4 == MODE_INCREMENTAL,
		prev_drive_q == $signed(result_q.drive),
		"previous drive differs from the delivered drive")
	`PIDPI_ASSERT_IMPL(a_drive_in_limit, result_valid_q && cfg.out_clamp_on,
		$signed(result_q.drive) <= $signed({1'b0, cfg.out_limit})
		&& $signed(result_q.drive) >= -$signed({1'b0, cfg.out_limit}),
		"drive outside the output limit")

endmodule
